/* sv/indexed_deque_list_defines.svh */
// ---------------------------------------------------------------------------
// indexed_deque_list assertion macros
// Shared property wrappers for the list engine checker.
// ---------------------------------------------------------------------------
`ifndef INDEXED_DEQUE_LIST_DEFINES_SVH
`define INDEXED_DEQUE_LIST_DEFINES_SVH

// same-cycle implication
`define IDL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: label failed");

// next-cycle implication
`define IDL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: label failed");

`endif

/* sv/idl_pkg.sv */
// ---------------------------------------------------------------------------
// idl_pkg
// Command and status codes and the cell control beat of the list engine.
// ---------------------------------------------------------------------------
`default_nettype none

package idl_pkg;

   localparam int IDX_W = 10;
   localparam int VAL_W = 32;

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_REAR   = 3'd3;
   localparam logic [2:0] CMD_INSERT     = 3'd4;
   localparam logic [2:0] CMD_REMOVE     = 3'd5;
   localparam logic [2:0] CMD_FIND       = 3'd6;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_BADPOS   = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_INS,
      OP_REM
   } op_type;

   typedef struct packed {
      op_type                   kind;
      logic [IDX_W-1:0]         at;
      logic [VAL_W-1:0]         value;
   } ctl_type;

endpackage

`default_nettype wire

/* sv/idl_cell.sv */
// ---------------------------------------------------------------------------
// idl_cell
// One list slot: holds an entry, shifts from either neighbor, compares.
// ---------------------------------------------------------------------------
`default_nettype none

module idl_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                        clock,
   input  wire idl_pkg::ctl_type            ctl,
   input  wire logic [idl_pkg::VAL_W-1:0]   left_q,
   input  wire logic [idl_pkg::VAL_W-1:0]   right_q,
   output logic      [idl_pkg::VAL_W-1:0]   data_q,
   output logic                             eq
);

   localparam logic [idl_pkg::IDX_W-1:0] MY_IDX = idl_pkg::IDX_W'(INDEX);

   logic [idl_pkg::VAL_W-1:0] data_ff;
   logic [idl_pkg::VAL_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctl.kind)
         idl_pkg::OP_INS: begin
            priority if (MY_IDX > ctl.at) begin
               data_in = left_q;
            end else if (MY_IDX == ctl.at) begin
               data_in = ctl.value;
            end else begin
               data_in = data_ff;
            end
         end
         idl_pkg::OP_REM: begin
            if (MY_IDX >= ctl.at) begin
               data_in = right_q;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;
   assign eq     = (data_ff == ctl.value);

endmodule

`default_nettype wire

/* sv/indexed_deque_list.sv */
// ---------------------------------------------------------------------------
// indexed_deque_list
// Bounded ordered list with push/pop at both ends, indexed insert/remove, find.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_cmd, req_value, req_position with start high;
//   the beat is taken on a clock edge where busy is low.
//   Result channel: rsp_valid strobes for one cycle with rsp_data_out,
//   rsp_found_index and rsp_status; the receiver must take it then.
//   The command is registered on its accept edge, executed in S_EXEC, and
//   its result is registered as the engine returns to S_IDLE, every command
//   alike. A new command is not taken until the engine is back in S_IDLE,
//   as S_EXEC is where the whole row of cells shifts or compares at once.
//   busy is high during the execute cycle only, so the next command can be
//   taken while the previous result is on the result ports.
//   Storage is a row of DEPTH cells, each one entry; insert shifts cells
//   right from the insert index, remove shifts them left.
//   Reset (synchronous, active high) empties the list and drops any result
//   in flight; entry contents are left as they are and never read unwritten.
//   The receiver cannot stall, so no result is ever held back.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_deque_list #(
   parameter int DEPTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic        [2:0]  req_cmd,
   input  wire logic signed [31:0] req_value,
   input  wire logic        [5:0]  req_position,
   output logic                    rsp_valid,
   output logic signed      [31:0] rsp_data_out,
   output logic             [4:0]  rsp_found_index,
   output logic             [2:0]  rsp_status
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = ((CW > 6) ? CW : 6) + 1;
   localparam int IW = idl_pkg::IDX_W;
   localparam int VW = idl_pkg::VAL_W;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type        state_ff;
   logic [2:0]       cmd_ff;
   logic [VW-1:0]    value_ff;
   logic [5:0]       pos_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic             rsp_valid_ff;
   logic [VW-1:0]    rsp_data_ff;
   logic [VW-1:0]    rsp_data_in;
   logic [4:0]       rsp_index_ff;
   logic [4:0]       rsp_index_in;
   logic [2:0]       rsp_status_ff;
   logic [2:0]       rsp_status_in;

   idl_pkg::ctl_type ctl;
   logic [VW-1:0]    cell_q [DEPTH];
   logic [DEPTH-1:0] cell_eq;

   logic [XW-1:0]    cnt_x;
   logic [XW-1:0]    pos_x;
   logic [XW-1:0]    at_x;
   logic             take_data;
   logic             found;
   logic [IW-1:0]    found_idx;
   logic [VW-1:0]    rd_data;

   always_comb begin
      cnt_x         = XW'(count_ff);
      pos_x         = XW'(pos_ff);
      at_x          = '0;
      take_data     = 1'b0;
      count_in      = count_ff;
      rsp_status_in = idl_pkg::ST_OK;
      ctl.kind      = idl_pkg::OP_NONE;
      ctl.value     = value_ff;
      found         = 1'b0;
      found_idx     = '0;
      rd_data       = '0;

      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (cell_eq[i] && (XW'(i) < cnt_x)) begin
            found     = 1'b1;
            found_idx = IW'(i);
         end
      end

      unique case (cmd_ff)
         idl_pkg::CMD_PUSH_FRONT, idl_pkg::CMD_PUSH_REAR: begin
            if (cnt_x == XW'(DEPTH)) begin
               rsp_status_in = idl_pkg::ST_FULL;
            end else begin
               ctl.kind = idl_pkg::OP_INS;
               at_x     = (cmd_ff == idl_pkg::CMD_PUSH_FRONT) ? '0 : cnt_x;
               count_in = count_ff + CW'(1);
            end
         end
         idl_pkg::CMD_POP_FRONT, idl_pkg::CMD_POP_REAR: begin
            if (cnt_x == '0) begin
               rsp_status_in = idl_pkg::ST_EMPTY;
            end else begin
               ctl.kind  = idl_pkg::OP_REM;
               take_data = 1'b1;
               at_x      = (cmd_ff == idl_pkg::CMD_POP_FRONT) ? '0 : cnt_x - XW'(1);
               count_in  = count_ff - CW'(1);
            end
         end
         idl_pkg::CMD_INSERT: begin
            priority if (pos_x > cnt_x) begin
               rsp_status_in = idl_pkg::ST_BADPOS;
            end else if (cnt_x == XW'(DEPTH)) begin
               rsp_status_in = idl_pkg::ST_FULL;
            end else begin
               ctl.kind = idl_pkg::OP_INS;
               at_x     = pos_x;
               count_in = count_ff + CW'(1);
            end
         end
         idl_pkg::CMD_REMOVE: begin
            priority if (cnt_x == '0) begin
               rsp_status_in = idl_pkg::ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
               rsp_status_in = idl_pkg::ST_BADPOS;
            end else begin
               ctl.kind  = idl_pkg::OP_REM;
               take_data = 1'b1;
               at_x      = pos_x;
               count_in  = count_ff - CW'(1);
            end
         end
         idl_pkg::CMD_FIND: begin
            rsp_status_in = found ? idl_pkg::ST_OK : idl_pkg::ST_NOTFOUND;
         end
         default: begin
            rsp_status_in = idl_pkg::ST_BADPOS;
         end
      endcase

      ctl.at = IW'(at_x);
      if (state_ff != S_EXEC) begin
         ctl.kind = idl_pkg::OP_NONE;
         count_in = count_ff;
      end

      for (int i = 0; i < DEPTH; i++) begin
         if (IW'(i) == ctl.at) begin
            rd_data = rd_data | cell_q[i];
         end
      end

      rsp_data_in  = take_data ? rd_data : '0;
      rsp_index_in = ((cmd_ff == idl_pkg::CMD_FIND) && found) ? found_idx[4:0] : 5'd0;
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [VW-1:0] left_q;
      logic [VW-1:0] right_q;

      if (g == 0) begin : g_first
         assign left_q = '0;
      end else begin : g_mid_l
         assign left_q = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_q = '0;
      end else begin : g_mid_r
         assign right_q = cell_q[g+1];
      end

      idl_cell #(
         .INDEX (g)
      ) u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .left_q  (left_q),
         .right_q (right_q),
         .data_q  (cell_q[g]),
         .eq      (cell_eq[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         unique case (state_ff)
            S_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (start) begin
                  state_ff <= S_EXEC;
                  cmd_ff   <= req_cmd;
                  value_ff <= req_value;
                  pos_ff   <= req_position;
               end
            end
            S_EXEC: begin
               state_ff      <= S_IDLE;
               rsp_valid_ff  <= 1'b1;
               rsp_data_ff   <= rsp_data_in;
               rsp_index_ff  <= rsp_index_in;
               rsp_status_ff <= rsp_status_in;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff == S_EXEC);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

/* sv/indexed_deque_list_checker.sv */
// ---------------------------------------------------------------------------
// indexed_deque_list_checker
// Port-level timing and status checks for the list engine.
// ---------------------------------------------------------------------------
`default_nettype none

`include "indexed_deque_list_defines.svh"

module indexed_deque_list_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [4:0] rsp_found_index,
   input wire logic [2:0] rsp_status
);

   `IDL_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `IDL_ASSERT_NEXT(a_busy_result, clock, reset, busy, rsp_valid && !busy)
   `IDL_ASSERT_NEXT(a_idle_quiet, clock, reset, !busy, !rsp_valid)
   `IDL_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status <= idl_pkg::ST_NOTFOUND)
   `IDL_ASSERT_NOW(a_index_ok, clock, reset, rsp_valid && (rsp_status != idl_pkg::ST_OK), rsp_found_index == 5'd0)

endmodule

bind indexed_deque_list indexed_deque_list_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_found_index (rsp_found_index),
   .rsp_status      (rsp_status)
);

`default_nettype wire
